### sv/dxbh_pkg.sv
package dxbh_pkg;

  // Field widths
  localparam int AddrW   = 48;
  localparam int ChanW   = 4;
  localparam int RankW   = 2;
  localparam int BgW     = 3;
  localparam int BankW   = 3;
  localparam int RowW    = 32;
  localparam int ColW    = 12;
  localparam int CfgIdxW = 3;
  localparam int CfgDatW = 5;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegXferOffset = 3'd0;
  localparam logic [CfgIdxW-1:0] RegChanBits   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegRankBits   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegBgBits     = 3'd3;
  localparam logic [CfgIdxW-1:0] RegBankBits   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegRowBits    = 3'd5;
  localparam logic [CfgIdxW-1:0] RegColBits    = 3'd6;

  // Reset values
  localparam logic [3:0] RstXferOffset = 4'd6;
  localparam logic [2:0] RstChanBits   = 3'd0;
  localparam logic [1:0] RstRankBits   = 2'd0;
  localparam logic [1:0] RstBgBits     = 2'd2;
  localparam logic [1:0] RstBankBits   = 2'd2;
  localparam logic [4:0] RstRowBits    = 5'd16;
  localparam logic [3:0] RstColBits    = 4'd7;

  // Low column bits taken straight from the address
  localparam int ColLowW = 2;
  localparam int ColUpW  = ColW - ColLowW;

endpackage

### sv/dram_address_xor_bank_hash.sv
// DRAM address mapper with XOR bank hashing, fixed order channel, rank,
// bankgroup, bank, row, column. The byte address drops transfer_offset bits,
// the two lowest bits become column bits 1:0, then channel, rank, bankgroup
// and bank are sliced at their configured widths, the upper column bits
// follow and everything left is the row (low 32 bits). Each level with a
// non-zero width is XORed with the next group of column bits. One item is
// accepted every cycle while in_stall is low (a full pipeline held by out_stall);
// out_valid rises once the item has passed the three register stages (shift,
// slice, hash). Each stage holds its item on its own when the output stalls,
// so bubbles are squeezed out. The user must write configuration through
// cfg_we/cfg_index/cfg_data only while idle; the block does not enforce it.
module dram_address_xor_bank_hash import dxbh_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgDatW-1:0] cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [AddrW-1:0]   byte_address,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [ChanW-1:0]   channel_id,
  output logic [RankW-1:0]   rank_id,
  output logic [BgW-1:0]     bankgroup_id,
  output logic [BankW-1:0]   bank_id,
  output logic [RowW-1:0]    row_id,
  output logic [ColW-1:0]    column_id
);

  // Configuration registers
  logic [3:0] transfer_offset;
  logic [2:0] channel_bits;
  logic [1:0] rank_bits;
  logic [1:0] bankgroup_bits;
  logic [1:0] bank_bits;
  logic [4:0] row_bits;
  logic [3:0] column_bits;

  always_ff @(posedge clk) begin
    if (rst) begin
      transfer_offset <= RstXferOffset;
      channel_bits    <= RstChanBits;
      rank_bits       <= RstRankBits;
      bankgroup_bits  <= RstBgBits;
      bank_bits       <= RstBankBits;
      row_bits        <= RstRowBits;
      column_bits     <= RstColBits;
    end else if (cfg_we) begin
      case (cfg_index)
        RegXferOffset: transfer_offset <= cfg_data[3:0];
        RegChanBits:   channel_bits    <= cfg_data[2:0];
        RegRankBits:   rank_bits       <= cfg_data[1:0];
        RegBgBits:     bankgroup_bits  <= cfg_data[1:0];
        RegBankBits:   bank_bits       <= cfg_data[1:0];
        RegRowBits:    row_bits        <= cfg_data[4:0];
        RegColBits:    column_bits     <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Clamped level widths and bit positions
  logic [2:0] w_chan;
  logic [1:0] w_rank;
  logic [3:0] col_up;
  logic [3:0] off_rank;   // from address bit 2
  logic [3:0] off_bg;
  logic [3:0] off_bank;
  logic [3:0] off_colup;
  logic [4:0] off_row;

  always_comb begin
    w_chan    = (channel_bits > 3'd4) ? 3'd4 : channel_bits;
    w_rank    = (rank_bits > 2'd2) ? 2'd2 : rank_bits;
    if (column_bits < 4'd2) begin
      col_up = 4'd0;
    end else if (column_bits > 4'd12) begin
      col_up = 4'd10;
    end else begin
      col_up = column_bits - 4'd2;
    end
    off_rank  = {1'b0, w_chan};
    off_bg    = off_rank + {2'b00, w_rank};
    off_bank  = off_bg + {2'b00, bankgroup_bits};
    off_colup = off_bank + {2'b00, bank_bits};
    off_row   = {1'b0, off_colup} + {1'b0, col_up};
  end

  // Stage handshakes: a stage loads when empty or when it moves on
  logic v1, v2, v3;
  logic en1, en2, en3;

  assign en3       = !v3 || !out_stall;
  assign en2       = !v2 || en3;
  assign en1       = !v1 || en2;
  assign in_stall  = !en1;
  assign out_valid = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  // Stage 1: drop the transfer offset
  logic [AddrW-1:0] a1;

  always_ff @(posedge clk) begin
    if (en1 && in_valid) a1 <= byte_address >> transfer_offset;
  end

  // Stage 2: slice the levels
  logic [AddrW-3:0] upper_a;
  logic [AddrW-3:0] sh_rank, sh_bg, sh_bank, sh_colup, sh_row;
  logic [ChanW-1:0] chan_s;
  logic [RankW-1:0] rank_s;
  logic [BgW-1:0]   bg_s;
  logic [BankW-1:0] bank_s;
  logic [ColUpW-1:0] colup_s;

  always_comb begin
    upper_a  = a1[AddrW-1:ColLowW];
    sh_rank  = upper_a >> off_rank;
    sh_bg    = upper_a >> off_bg;
    sh_bank  = upper_a >> off_bank;
    sh_colup = upper_a >> off_colup;
    sh_row   = upper_a >> off_row;
    chan_s   = upper_a[ChanW-1:0] & ~(4'hF << w_chan);
    rank_s   = sh_rank[RankW-1:0] & ~(2'h3 << w_rank);
    bg_s     = sh_bg[BgW-1:0] & ~(3'h7 << bankgroup_bits);
    bank_s   = sh_bank[BankW-1:0] & ~(3'h7 << bank_bits);
    colup_s  = sh_colup[ColUpW-1:0] & ~({ColUpW{1'b1}} << col_up);
  end

  logic [ChanW-1:0] chan2;
  logic [RankW-1:0] rank2;
  logic [BgW-1:0]   bg2;
  logic [BankW-1:0] bank2;
  logic [RowW-1:0]  row2;
  logic [ColW-1:0]  col2;

  always_ff @(posedge clk) begin
    if (en2 && v1) begin
      chan2 <= chan_s;
      rank2 <= rank_s;
      bg2   <= bg_s;
      bank2 <= bank_s;
      row2  <= sh_row[RowW-1:0];
      col2  <= {colup_s, a1[ColLowW-1:0]};
    end
  end

  // Stage 3: XOR each level with its column group
  logic [RowW-1:0] col_ext;
  logic [RowW-1:0] g_rank, g_bg, g_bank, g_row;
  logic [ChanW-1:0] g_chan;

  always_comb begin
    col_ext = {{(RowW-ColW){1'b0}}, col2};
    g_chan  = col2[ChanW-1:0] & ~(4'hF << w_chan);
    g_rank  = col_ext >> off_rank;
    g_bg    = col_ext >> off_bg;
    g_bank  = col_ext >> off_bank;
    g_row   = (col_ext >> off_colup) & ~(32'hFFFF_FFFF << row_bits);
  end

  always_ff @(posedge clk) begin
    if (en3 && v2) begin
      channel_id   <= chan2 ^ g_chan;
      rank_id      <= rank2 ^ (g_rank[RankW-1:0] & ~(2'h3 << w_rank));
      bankgroup_id <= bg2 ^ (g_bg[BgW-1:0] & ~(3'h7 << bankgroup_bits));
      bank_id      <= bank2 ^ (g_bank[BankW-1:0] & ~(3'h7 << bank_bits));
      row_id       <= row2 ^ g_row;
      column_id    <= col2;
    end
  end

endmodule
